[rtl/core/oha_pkg.sv]
// Shared codes, defaults and result type for the ownership handover arbiter.
package oha_pkg;

	localparam int OHA_COUNT_BITS = 32;

	localparam logic [2:0] CMD_REQUEST  = 3'd0;
	localparam logic [2:0] CMD_PROMOTE  = 3'd1;
	localparam logic [2:0] CMD_DEMOTE   = 3'd2;
	localparam logic [2:0] CMD_RESET    = 3'd3;
	localparam logic [2:0] CMD_BEGIN    = 3'd4;
	localparam logic [2:0] CMD_ACK      = 3'd5;
	localparam logic [2:0] CMD_COMPLETE = 3'd6;

	localparam logic [1:0] WHO_NONE     = 2'd0;
	localparam logic [1:0] WHO_REALTIME = 2'd1;
	localparam logic [1:0] WHO_REPLAY   = 2'd2;

	localparam logic [1:0] MODE_COLD       = 2'd0;
	localparam logic [1:0] MODE_ARMED      = 2'd2;
	localparam logic [1:0] MODE_PERFORMING = 2'd3;

	typedef struct packed {
		logic [63:0] generation;
		logic        granted;
		logic        release_wanted;
		logic [1:0]  owner;
		logic [1:0]  mode;
		logic        pending;
		logic [31:0] grants;
		logic [31:0] refusals;
	} oha_res_t;

endpackage

[rtl/core/ownership_handover_arbiter.sv]
// Top level: command input register, arbiter logic and result register.
//
//   channel  valid      ready      payload
//   command  cmd_valid  cmd_ready  command, requester, wanted_mode, last_frame, tag
//   result   rsp_valid  rsp_ready  result_generation .. refusals
//
// One command per cycle while rsp_ready stays high; the result is valid after the
// command transfer has passed the input register, then the result register.
// The command register refills in the cycle its item moves to the result register;
// a held result still takes one further command in, then cmd_ready drops.
// arst_n clears owner, mode, generations and counters; no result is pending after it.
module ownership_handover_arbiter import oha_pkg::*; #(
	parameter int COUNT_BITS = OHA_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  command,
	input  logic [1:0]  requester,
	input  logic [1:0]  wanted_mode,
	input  logic [63:0] last_frame,
	input  logic [63:0] tag,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [63:0] result_generation,
	output logic        granted,
	output logic        release_wanted,
	output logic [1:0]  owner_now,
	output logic [1:0]  mode_now,
	output logic        handover_pending,
	output logic [31:0] grants_done,
	output logic [31:0] refusals
);

	logic        vld_s1;
	logic [2:0]  cmd_s1;
	logic [1:0]  who_s1, want_s1;
	logic [63:0] frame_s1, tag_s1;
	logic        out_vld_q;
	oha_res_t    res, res_q;
	logic        adv;

	assign adv       = vld_s1 && (!out_vld_q || rsp_ready);
	assign cmd_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd_ready) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1   <= command;
			who_s1   <= requester;
			want_s1  <= wanted_mode;
			frame_s1 <= last_frame;
			tag_s1   <= tag;
		end
	end

	oha_ctrl #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(adv),
		.cmd    (cmd_s1),
		.who_in (who_s1),
		.want   (want_s1),
		.frame  (frame_s1),
		.tag    (tag_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || rsp_ready) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign rsp_valid         = out_vld_q;
	assign result_generation = res_q.generation;
	assign granted           = res_q.granted;
	assign release_wanted    = res_q.release_wanted;
	assign owner_now         = res_q.owner;
	assign mode_now          = res_q.mode;
	assign handover_pending  = res_q.pending;
	assign grants_done       = res_q.grants;
	assign refusals          = res_q.refusals;

endmodule

[rtl/core/oha_ctrl.sv]
// Arbiter state registers and the per-command next-state and result logic.
module oha_ctrl import oha_pkg::*; #(
	parameter int COUNT_BITS = OHA_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [2:0]  cmd,
	input  logic [1:0]  who_in,
	input  logic [1:0]  want,
	input  logic [63:0] frame,
	input  logic [63:0] tag,
	output oha_res_t    res
);

	logic [1:0]            owner_q, tgt_owner_q, mode_q, tgt_mode_q;
	logic                  pend_q;
	logic [63:0]           req_gen_q, acked_gen_q, rel_frame_q;
	logic [COUNT_BITS-1:0] xfer_cnt_q, deny_cnt_q;

	logic [1:0]            owner_d, tgt_owner_d, mode_d, tgt_mode_d;
	logic                  pend_d;
	logic [63:0]           req_gen_d, acked_gen_d, rel_frame_d;
	logic [COUNT_BITS-1:0] xfer_cnt_d, deny_cnt_d;
	logic [63:0]           gen_out, req_gen_inc, xfer_ext, deny_ext;
	logic [1:0]            who;
	logic                  ok, rel;

	assign who = (who_in == WHO_REALTIME || who_in == WHO_REPLAY) ? who_in : WHO_NONE;
	assign req_gen_inc = req_gen_q + 64'd1;

	always_comb begin
		owner_d     = owner_q;
		tgt_owner_d = tgt_owner_q;
		mode_d      = mode_q;
		tgt_mode_d  = tgt_mode_q;
		pend_d      = pend_q;
		req_gen_d   = req_gen_q;
		acked_gen_d = acked_gen_q;
		rel_frame_d = rel_frame_q;
		xfer_cnt_d  = xfer_cnt_q;
		deny_cnt_d  = deny_cnt_q;
		gen_out     = 64'd0;
		ok          = 1'b0;
		rel         = 1'b0;
		unique case (cmd)
			CMD_REQUEST: begin
				if (!pend_q) begin
					if (owner_q == who && mode_q == want) begin
						gen_out = req_gen_q;
						ok      = 1'b1;
					end else begin
						tgt_owner_d = who;
						tgt_mode_d  = want;
						req_gen_d   = req_gen_inc;
						gen_out     = req_gen_inc;
						if (owner_q == WHO_NONE || owner_q == who) begin
							mode_d     = want;
							owner_d    = who;
							xfer_cnt_d = xfer_cnt_q + COUNT_BITS'(1);
							ok         = 1'b1;
						end else begin
							pend_d = 1'b1;
						end
					end
				end
			end
			CMD_PROMOTE: begin
				if (owner_q == WHO_REALTIME && !pend_q &&
				    (mode_q == MODE_ARMED || mode_q == MODE_PERFORMING)) begin
					mode_d = MODE_PERFORMING;
					ok     = 1'b1;
				end
			end
			CMD_DEMOTE: begin
				if (owner_q == WHO_REALTIME &&
				    (mode_q == MODE_ARMED || mode_q == MODE_PERFORMING)) begin
					mode_d = MODE_ARMED;
					ok     = 1'b1;
				end
			end
			CMD_RESET: begin
				pend_d      = 1'b0;
				owner_d     = WHO_NONE;
				tgt_owner_d = WHO_NONE;
				mode_d      = MODE_COLD;
				tgt_mode_d  = MODE_COLD;
				ok          = 1'b1;
			end
			CMD_BEGIN: begin
				if (owner_q != who) begin
					deny_cnt_d = deny_cnt_q + COUNT_BITS'(1);
				end else begin
					gen_out = req_gen_q;
					ok      = 1'b1;
					rel     = pend_q && (tgt_owner_q != who);
				end
			end
			CMD_ACK: begin
				if (pend_q && tag == req_gen_q && owner_q == who) begin
					rel_frame_d = frame;
					owner_d     = WHO_NONE;
					acked_gen_d = tag;
					ok          = 1'b1;
				end
			end
			CMD_COMPLETE: begin
				if (tag != 64'd0 && req_gen_q == tag) begin
					if (!pend_q) begin
						ok = 1'b1;
					end else if (acked_gen_q == tag) begin
						mode_d     = tgt_mode_q;
						pend_d     = 1'b0;
						owner_d    = tgt_owner_q;
						xfer_cnt_d = xfer_cnt_q + COUNT_BITS'(1);
						ok         = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q     <= WHO_NONE;
			tgt_owner_q <= WHO_NONE;
			mode_q      <= MODE_COLD;
			tgt_mode_q  <= MODE_COLD;
			pend_q      <= 1'b0;
			req_gen_q   <= 64'd0;
			acked_gen_q <= 64'd0;
			rel_frame_q <= 64'd0;
			xfer_cnt_q  <= '0;
			deny_cnt_q  <= '0;
		end else if (step_en) begin
			owner_q     <= owner_d;
			tgt_owner_q <= tgt_owner_d;
			mode_q      <= mode_d;
			tgt_mode_q  <= tgt_mode_d;
			pend_q      <= pend_d;
			req_gen_q   <= req_gen_d;
			acked_gen_q <= acked_gen_d;
			rel_frame_q <= rel_frame_d;
			xfer_cnt_q  <= xfer_cnt_d;
			deny_cnt_q  <= deny_cnt_d;
		end
	end

	assign xfer_ext = 64'(xfer_cnt_d);
	assign deny_ext = 64'(deny_cnt_d);

	always_comb begin
		res.generation     = gen_out;
		res.granted        = ok;
		res.release_wanted = rel;
		res.owner          = owner_d;
		res.mode           = mode_d;
		res.pending        = pend_d;
		res.grants         = xfer_ext[31:0];
		res.refusals       = deny_ext[31:0];
	end

	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && cmd == CMD_RESET |=> !pend_q && owner_q == WHO_NONE && mode_q == MODE_COLD)
		else $error("reset command left owner, mode or pending set");

	a_ack_frame: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && cmd == CMD_ACK && ok |=> rel_frame_q == $past(frame) && owner_q == WHO_NONE)
		else $error("acknowledge did not record frame or release owner");

	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> req_gen_q == $past(req_gen_q) || req_gen_q == $past(req_gen_q) + 64'd1)
		else $error("request generation moved by more than one");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(xfer_cnt_q) && $stable(deny_cnt_q) && $stable(pend_q))
		else $error("state changed without a command");

endmodule
